/* rtl/lbp_3x3_code_stream_macros.svh */
// Assertion macros for the LBP code stream block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef LBP_3X3_CODE_STREAM_MACROS_SVH
`define LBP_3X3_CODE_STREAM_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lbp_pkg.sv */
// Shared types, constants and helpers for the LBP code stream block.
// No dependencies; compiled first.
package lbp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W     = 8;
  localparam int CODE_W    = 8;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 11;
  localparam int DIM_W     = 12;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W = 1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;

  localparam dim_t WIDTH_RST  = 12'd640;
  localparam dim_t HEIGHT_RST = 12'd480;

  // One line-store entry: both stored rows for one column
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  // Line memory access request
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
  } mem_req_t;

  // Limit a programmed dimension to [3, hi]
  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    dim_t res;
    if (v < dim_t'(3)) begin
      res = dim_t'(3);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

/* rtl/lbp_channels.sv */
// Valid/ready channel interfaces: pixel input, code output, config write.
// Depends on lbp_pkg.
interface lbp_pix_if;
  import lbp_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel_value;
  logic frame_start;
  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface lbp_code_if;
  import lbp_pkg::*;
  logic  valid;
  logic  ready;
  code_t pattern_code;
  row_t  centre_row;
  col_t  centre_column;
  logic  frame_last;
  modport source (output valid, output pattern_code, output centre_row,
                  output centre_column, output frame_last, input ready);
  modport sink   (input valid, input pattern_code, input centre_row,
                  input centre_column, input frame_last, output ready);
endinterface

interface lbp_cfg_if;
  import lbp_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/lbp_line_mem.sv */
// Two-row line store: one synchronous RAM, one write and one read port,
// registered read data (old data on same-address write).
// Depends on lbp_pkg.
module lbp_line_mem (
  input  logic               clk,
  input  lbp_pkg::mem_req_t  req,
  input  lbp_pkg::line_pair_t wr_data,
  output lbp_pkg::line_pair_t rd_data
);
  import lbp_pkg::*;

  line_pair_t mem [MAX_WIDTH];
  line_pair_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // read port, data held when no read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lbp_3x3_code_stream.sv */
// Top level of the 3x3 local binary pattern code stream.
// Depends on lbp_pkg, lbp_channels, lbp_line_mem and the assertion macros.
//
//  channel   dir  payload                                           request taken
//  in_pix    in   pixel_value[7:0] frame_start                      valid & ready
//  out_code  out  pattern_code[7:0] centre_row[10:0]
//                 centre_column[10:0] frame_last                    valid & ready
//  cfg_wr    in   index[0:0] data[11:0]                             valid & ready
//
// One pixel per clock sustained while the output takes codes; a taken pixel is
// registered in stage 1 (line RAM read at the accepting edge), then compare and
// write-back move its code into the output register.
// The line RAM read latency sets the two-stage depth; a same-column back-to-back
// access is served by a bypass register. Output stall holds the compare stage;
// the input keeps flowing while that stage is free. Reset is synchronous; the
// line RAM is not cleared and needs no clearing pass. cfg_wr is always ready.
module lbp_3x3_code_stream (
  input logic      clk,
  input logic      rst_n,
  lbp_pix_if.sink  in_pix,
  lbp_code_if.source out_code,
  lbp_cfg_if.sink  cfg_wr
);
  import lbp_pkg::*;

  // configuration
  dim_t width_r, height_r;
  dim_t w_use, h_use;

  // position counters (next pixel)
  col_t col_r, col_nxt;
  row_t row_r, row_nxt;

  // stage 1: item waiting on RAM data
  logic  s1_v_r, s1_v_nxt;
  addr_t s1_addr_r;
  logic  s1_emit_r;
  row_t  s1_row_r;
  col_t  s1_col_r;
  logic  s1_last_r;
  pix_t  s1_cur_r;
  logic  byp_r;
  pix_t  byp_up_r, byp_mid_r;

  // window: 0..2 two columns back, 3..5 one column back (upper/middle/lower)
  pix_t win_r [6];

  // output register
  logic  out_v_r, out_v_nxt;
  code_t out_code_r;
  row_t  out_row_r;
  col_t  out_col_r;
  logic  out_last_r;

  logic  in_acc, s1_adv;
  col_t  c_cur;
  row_t  r_cur;
  logic  col_wrap;
  logic  emit, last;
  pix_t  up, mid, ctr;
  code_t code;
  mem_req_t   mreq;
  line_pair_t mem_wdata, mem_rdata;

  assign w_use = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign h_use = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));

  // handshake
  assign s1_adv = s1_v_r && (!s1_emit_r || !out_v_r || out_code.ready);
  assign in_pix.ready = !s1_v_r || s1_adv;
  assign in_acc = in_pix.valid && in_pix.ready;
  assign cfg_wr.ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr.data;
        REG_IMAGE_HEIGHT: height_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // position of the accepted pixel and counter advance
  always_comb begin
    c_cur    = in_pix.frame_start ? '0 : col_r;
    r_cur    = in_pix.frame_start ? '0 : row_r;
    col_wrap = ({1'b0, c_cur} + dim_t'(1)) >= w_use;
    emit     = (r_cur >= row_t'(2)) && (c_cur >= col_t'(2));
    last     = (({1'b0, r_cur} + dim_t'(1)) == h_use) &&
               (({1'b0, c_cur} + dim_t'(1)) == w_use);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_acc) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (({1'b0, r_cur} + dim_t'(1)) >= h_use) ? '0 : r_cur + row_t'(1);
      end else begin
        col_nxt = c_cur + col_t'(1);
        row_nxt = r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1 data, with bypass when the previous item writes the same column now
  assign up  = byp_r ? byp_up_r  : mem_rdata.upper;
  assign mid = byp_r ? byp_mid_r : mem_rdata.middle;
  assign ctr = win_r[4];

  assign s1_v_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (in_acc) begin
        byp_r <= s1_adv && (addr_t'(c_cur) == s1_addr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r <= addr_t'(c_cur);
      s1_emit_r <= emit;
      s1_row_r  <= r_cur - row_t'(1);
      s1_col_r  <= c_cur - col_t'(1);
      s1_last_r <= last;
      s1_cur_r  <= in_pix.pixel_value;
      byp_up_r  <= mid;
      byp_mid_r <= s1_cur_r;
    end
  end

  // line RAM: read at accept, write back when stage 1 retires
  always_comb begin
    mreq.rd_en   = in_acc;
    mreq.rd_addr = addr_t'(c_cur);
    mreq.wr_en   = s1_adv;
    mreq.wr_addr = s1_addr_r;
    mem_wdata.upper  = mid;
    mem_wdata.middle = s1_cur_r;
  end

  lbp_line_mem u_line_mem (
    .clk     (clk),
    .req     (mreq),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  // eight neighbor compares against the centre
  always_comb begin
    code[7] = win_r[0] >= ctr;
    code[6] = win_r[3] >= ctr;
    code[5] = up >= ctr;
    code[4] = mid >= ctr;
    code[3] = s1_cur_r >= ctr;
    code[2] = win_r[5] >= ctr;
    code[1] = win_r[2] >= ctr;
    code[0] = win_r[1] >= ctr;
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up;
      win_r[4] <= mid;
      win_r[5] <= s1_cur_r;
    end
  end

  // output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv && s1_emit_r) begin
      out_v_nxt = 1'b1;
    end else if (out_code.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_code_r <= code;
      out_row_r  <= s1_row_r;
      out_col_r  <= s1_col_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_code.valid         = out_v_r;
  assign out_code.pattern_code  = out_code_r;
  assign out_code.centre_row    = out_row_r;
  assign out_code.centre_column = out_col_r;
  assign out_code.frame_last    = out_last_r;

  // checks
  `include "lbp_3x3_code_stream_macros.svh"

  `LBP_ASSERT_IMP(a_centre_interior, out_v_r, (out_row_r != '0) && (out_col_r != '0), "code on border")
  `LBP_ASSERT_IMP(a_last_position, out_v_r && out_last_r, (({1'b0, out_row_r} + dim_t'(2)) == h_use) && (({1'b0, out_col_r} + dim_t'(2)) == w_use), "frame_last off position")
  `LBP_ASSERT_NXT(a_frame_start, in_acc && in_pix.frame_start, (col_r == col_t'(1)) && (row_r == '0), "frame start did not restart counters")
  `LBP_ASSERT_IMP(a_bypass_owner, byp_r, s1_v_r || !s1_emit_r || out_v_r, "bypass without pending item")

endmodule
